// ===== hdl/morse_number_check_encoder_assert.svh =====
// assertion macros shared by the checker
`ifndef MORSE_NUMBER_CHECK_ENCODER_ASSERT_SVH
`define MORSE_NUMBER_CHECK_ENCODER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define MNCE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mnce assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define MNCE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mnce assertion failed");

`endif

// ===== hdl/mnce_pkg.sv =====
package mnce_pkg;

  // configuration defaults
  localparam int unsigned MNCE_DIGITS = 4;
  localparam int unsigned MNCE_QDEPTH = 2;

  // field widths
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned DUR_W   = 3;
  localparam int unsigned GAP_W   = 3;
  localparam int unsigned POS_W   = 4;

  // symbol timing in dits
  localparam logic [DUR_W-1:0] DOT_LEN   = 3'd1;
  localparam logic [DUR_W-1:0] DASH_LEN  = 3'd3;
  localparam logic [DUR_W-1:0] INNER_GAP = 3'd1;
  localparam logic [DUR_W-1:0] DIGIT_GAP = 3'd3;
  localparam logic [DUR_W-1:0] END_LEN   = 3'd0;
  localparam logic [GAP_W-1:0] CHECK_GAP_RST = 3'd3;

  // entries per digit, last position of a digit
  localparam logic [POS_W-1:0] POS_LAST = 4'd9;
  localparam logic [DIGIT_W-1:0] DEC_BASE = 4'd10;
  localparam logic [DIGIT_W-1:0] HALF_BASE = 4'd5;

  // divide by ten: q = (n * RECIP10) >> RECIP10_SH, exact for 16-bit n
  localparam int unsigned RECIP10_W  = 17;
  localparam logic [RECIP10_W-1:0] RECIP10 = 17'd52429;
  localparam int unsigned RECIP10_SH = 19;
  localparam int unsigned PROD_W     = VALUE_W + RECIP10_W;
  localparam int unsigned QUO_W      = PROD_W - RECIP10_SH;

  // queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/mnce_front.sv =====
module mnce_front
  import mnce_pkg::*;
#(
  parameter int unsigned DIGITS = MNCE_DIGITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [VALUE_W-1:0]           value_i,
  output logic                         busy_o,
  input  q_stat_t                      q_stat_i,
  output logic                         push_o,
  output logic [(DIGITS+1)*DIGIT_W-1:0] push_data_o
);

  localparam int unsigned DW = $clog2(DIGITS + 1);
  localparam int unsigned SW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PUSH
  } state_e;

  state_e               state_q;
  logic [VALUE_W-1:0]   n_q;
  logic [SW-1:0]        step_q;
  logic [DIGIT_W-1:0]   csum_q;
  logic [DIGIT_W-1:0]   digits_q [DIGITS+1];

  logic [PROD_W-1:0]    prod;
  logic [QUO_W-1:0]     quo;
  logic [VALUE_W-1:0]   rem_full;
  logic [DIGIT_W-1:0]   dig;
  logic [DIGIT_W:0]     comp;
  logic [DIGIT_W:0]     sum;
  logic [DIGIT_W-1:0]   csum_d;
  logic [DW-1:0]        slot;

  // one decimal digit per cycle by reciprocal multiply
  always_comb begin
    prod     = PROD_W'(n_q) * PROD_W'(RECIP10);
    quo      = prod[PROD_W-1:RECIP10_SH];
    rem_full = n_q - (VALUE_W'(quo) << 3) - (VALUE_W'(quo) << 1);
    dig      = rem_full[DIGIT_W-1:0];
  end

  // running check sum of (10 - digit) mod 10
  always_comb begin
    comp = (dig == '0) ? '0 : {1'b0, DEC_BASE - dig};
    sum  = {1'b0, csum_q} + comp;
    if (sum >= {1'b0, DEC_BASE}) begin
      csum_d = sum[DIGIT_W-1:0] - DEC_BASE;
    end else begin
      csum_d = sum[DIGIT_W-1:0];
    end
    slot = DW'(DIGITS - 1) - DW'(step_q);
  end

  // sequencer over the digits of one request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      csum_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_CONV;
            step_q  <= '0;
            csum_q  <= '0;
          end
        end
        ST_CONV: begin
          csum_q <= csum_d;
          if (step_q == SW'(DIGITS - 1)) begin
            state_q <= ST_PUSH;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_PUSH: begin
          if (!q_stat_i.full) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      n_q <= value_i;
    end else if (state_q == ST_CONV) begin
      n_q <= VALUE_W'(quo);
      digits_q[slot] <= dig;
      if (step_q == SW'(DIGITS - 1)) begin
        digits_q[DIGITS] <= csum_d;
      end
    end
  end

  // flatten digits, slot 0 is sent first
  always_comb begin
    for (int k = 0; k <= DIGITS; k++) begin
      push_data_o[k*DIGIT_W +: DIGIT_W] = digits_q[k];
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign push_o = (state_q == ST_PUSH) && !q_stat_i.full;

endmodule

// ===== hdl/mnce_queue.sv =====
module mnce_queue
  import mnce_pkg::*;
#(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = MNCE_QDEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output q_stat_t          stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q;
  logic [PW-1:0]    rd_ptr_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push;
  logic             do_pop;

  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/mnce_back.sv =====
module mnce_back
  import mnce_pkg::*;
#(
  parameter int unsigned DIGITS = MNCE_DIGITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  q_stat_t                       q_stat_i,
  input  logic [(DIGITS+1)*DIGIT_W-1:0] pop_data_i,
  output logic                          pop_o,
  input  logic [GAP_W-1:0]              check_gap_i,
  output logic                          strobe_o,
  output logic [DUR_W-1:0]              duration_o,
  output logic                          is_mark_o,
  output logic                          last_o
);

  localparam int unsigned DW = $clog2(DIGITS + 1);
  localparam int unsigned EW = (DIGITS + 1) * DIGIT_W;

  logic                act_q;
  logic [DW-1:0]       dig_q;
  logic [POS_W-1:0]    pos_q;
  logic [EW-1:0]       ent_q;
  logic                strobe_q;
  logic [DUR_W-1:0]    dur_q;
  logic                mark_q;
  logic                last_q;

  logic [DIGIT_W-1:0]  cur;
  logic [2:0]          elem;
  logic [DIGIT_W-1:0]  n_first;
  logic [DUR_W-1:0]    first_len;
  logic [DUR_W-1:0]    second_len;
  logic [DUR_W-1:0]    gap_eff;
  logic [DUR_W-1:0]    dur;
  logic                at_end;
  logic                fin;

  // symbol for the current digit and position
  always_comb begin
    cur  = ent_q[{dig_q, 2'b00} +: DIGIT_W];
    elem = pos_q[3:1];
    if (cur >= HALF_BASE) begin
      n_first    = cur - HALF_BASE;
      first_len  = DASH_LEN;
      second_len = DOT_LEN;
    end else begin
      n_first    = cur;
      first_len  = DOT_LEN;
      second_len = DASH_LEN;
    end
    gap_eff = (check_gap_i == '0) ? DUR_W'(1) : check_gap_i;
    at_end  = (dig_q == DW'(DIGITS)) && (pos_q == POS_LAST);
    if (!pos_q[0]) begin
      dur = ({1'b0, elem} < n_first) ? first_len : second_len;
    end else if (pos_q != POS_LAST) begin
      dur = INNER_GAP;
    end else if (dig_q == DW'(DIGITS)) begin
      dur = END_LEN;
    end else if (dig_q == DW'(DIGITS - 1)) begin
      dur = gap_eff;
    end else begin
      dur = DIGIT_GAP;
    end
  end

  assign fin   = act_q && at_end;
  assign pop_o = (!act_q || fin) && !q_stat_i.empty;

  // position counters and request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= 1'b0;
      dig_q    <= '0;
      pos_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= act_q;
      if (pop_o) begin
        act_q <= 1'b1;
        dig_q <= '0;
        pos_q <= '0;
      end else if (fin) begin
        act_q <= 1'b0;
      end else if (act_q) begin
        if (pos_q == POS_LAST) begin
          pos_q <= '0;
          dig_q <= dig_q + 1'b1;
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= pop_data_i;
    end
    dur_q  <= dur;
    mark_q <= !pos_q[0];
    last_q <= at_end;
  end

  assign strobe_o   = strobe_q;
  assign duration_o = dur_q;
  assign is_mark_o  = mark_q;
  assign last_o     = last_q;

endmodule

// ===== hdl/morse_number_check_encoder.sv =====
// morse_number_check_encoder
// spells the lowest DIGITS decimal digits of value_i in morse, most
// significant first with leading zeros, then a check digit that makes all
// digits sum to 0 mod 10; each digit is ten entries (five elements, five gaps)
// request channel: value_i is taken at a clock edge with start_i high and
// busy_o low
// result channel: strobe_o marks one entry per cycle on duration_o,
// is_mark_o and last_o; last_o marks the zero-length terminator entry
// a request yields 10*(DIGITS+1) entries, sent on consecutive cycles
// requests are paced by the output sequencer, which emits one entry per cycle
// while a request is active; a two-entry queue lets the digit converter run
// ahead, and busy_o is high while the converter works or waits for room in
// the queue
// path: converter, queue, then the output sequencer with registered outputs
// config: cfg_we_i writes cfg_wdata_i into the check gap, reset value 3;
// write only while no request is in flight
// reset: queue empties, sequencers idle, no entries are sent
// the receiver cannot stall: every strobe is taken in its own cycle
module morse_number_check_encoder
  import mnce_pkg::*;
#(
  parameter int unsigned DIGITS = MNCE_DIGITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic               busy_o,
  input  logic               cfg_we_i,
  input  logic [GAP_W-1:0]   cfg_wdata_i,
  output logic               strobe_o,
  output logic [DUR_W-1:0]   duration_o,
  output logic               is_mark_o,
  output logic               last_o
);

  localparam int unsigned EW = (DIGITS + 1) * DIGIT_W;

  logic [GAP_W-1:0] check_gap_q;
  q_stat_t          q_stat;
  logic             push;
  logic [EW-1:0]    push_data;
  logic             pop;
  logic [EW-1:0]    pop_data;

  // check gap register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_gap_q <= CHECK_GAP_RST;
    end else if (cfg_we_i) begin
      check_gap_q <= cfg_wdata_i;
    end
  end

  // digit conversion
  mnce_front #(
    .DIGITS(DIGITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .value_i    (value_i),
    .busy_o     (busy_o),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .push_data_o(push_data)
  );

  // queue between converter and sequencer
  mnce_queue #(
    .WIDTH(EW),
    .DEPTH(MNCE_QDEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .stat_o     (q_stat)
  );

  // symbol sequencer
  mnce_back #(
    .DIGITS(DIGITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .check_gap_i(check_gap_q),
    .strobe_o   (strobe_o),
    .duration_o (duration_o),
    .is_mark_o  (is_mark_o),
    .last_o     (last_o)
  );

endmodule

// ===== hdl/mnce_checker.sv =====
`include "morse_number_check_encoder_assert.svh"

module mnce_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       strobe_o,
  input logic [2:0] duration_o,
  input logic       is_mark_o,
  input logic       last_o
);

  // terminator carries zero length
  `MNCE_ASSERT_IMP(a_last_zero, strobe_o && last_o, duration_o == 3'd0)

  // every other entry has a length
  `MNCE_ASSERT_IMP(a_body_nonzero, strobe_o && !last_o, duration_o != 3'd0)

  // elements are dots or dashes
  `MNCE_ASSERT_IMP(a_mark_len, strobe_o && is_mark_o, duration_o == 3'd1 || duration_o == 3'd3)

  // each element is followed by a gap in the next cycle
  `MNCE_ASSERT_NXT(a_mark_gap, strobe_o && is_mark_o, strobe_o && !is_mark_o)

  // an accepted request makes the block busy
  `MNCE_ASSERT_NXT(a_accept_busy, start_i && !busy_o, busy_o)

endmodule

bind morse_number_check_encoder mnce_checker u_chk (.*);
